// File: src/mpre_pkg.sv
// shared types and constants of the multichannel ping retry engine
package mpre_pkg;

	// channel table size and per-item result cap
	localparam int CHANNELS_DEF = 8;
	localparam int MAX_RESULTS  = 8;

	// identifier word after reset and its step per request
	localparam logic [31:0] SEQ_RESET = 32'h1004_3119;
	localparam logic [31:0] SEQ_STEP  = 32'h0001_0001;

	// attempt count saturates here
	localparam logic [7:0] ATTEMPTS_MAX = 8'hFF;

	// item function codes
	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_START = 2'd1,
		FN_STOP  = 2'd2,
		FN_REPLY = 2'd3
	} func_t;

	// result kinds
	typedef enum logic {
		EV_SEND = 1'b0,
		EV_DONE = 1'b1
	} ev_kind_t;

	// channel phases
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_ARMED = 3'd1,
		PH_RETRY = 3'd2,
		PH_WAIT  = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_WALK  = 2'd1,
		ST_FLUSH = 2'd2
	} state_t;

	// command item
	typedef struct packed {
		func_t       func;
		logic [2:0]  channel_sel;
		logic [31:0] target_ip;
		logic        ip_valid;
		logic [31:0] timeout_ticks;
		logic [7:0]  max_retries;
		logic [31:0] reply_id;
		logic [31:0] reply_src_ip;
		logic [31:0] now;
		logic [3:0]  tx_credits;
	} cmd_item_t;

	// result item
	typedef struct packed {
		logic [2:0]  channel_num;
		ev_kind_t    event_kind;
		logic [31:0] seq_id;
		logic [31:0] dest_ip;
		logic        success;
		logic        last;
	} evt_item_t;

	// channel settings written by a start item
	typedef struct packed {
		logic [31:0] addr;
		logic        addr_ok;
		logic [31:0] timeout;
		logic [7:0]  limit;
	} chan_cfg_t;

	// channel progress written by the walk
	typedef struct packed {
		logic [7:0]  attempts;
		logic [31:0] deadline;
		logic [31:0] expect_id;
	} chan_dyn_t;

endpackage

// File: src/multichannel_ping_retry_engine.sv
// top level of the multichannel ping retry engine
//
// Usage: commands enter on the cmd channel (cmd_valid, cmd_stall, cmd) and
// results leave on the evt channel (evt_valid, evt_stall, evt). A start item
// loads a channel's target, timeout and retry limit and arms it; a stop item
// idles it. Both give no result.
// A tick or reply item walks the channel table, one channel per cycle
// unless a stalled receiver pauses it: the settings and progress memories
// are read into registers ahead of evaluation, and progress and phases are
// written back in the evaluation cycle. No new item is taken before the
// walk is through. A result is held until the walk makes the next one or
// ends; the final one carries last.
// Results pass a one-entry holding stage and a registered output, so a
// stalled receiver only pauses the walk when both are full; cmd_stall stays
// high for the whole walk and until the final result is in the output
// register.
// Reset idles every channel and loads the identifier counter; the memories
// need no clearing pass, only channels a start item armed use their data.
module multichannel_ping_retry_engine
	import mpre_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	output logic      evt_valid,
	input  logic      evt_stall,
	output evt_item_t evt
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	// sequencer and walk registers
	state_t            state_q, state_d;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	func_t             func_q;
	logic [31:0]       now_q;
	logic [3:0]        cred_q;
	logic [31:0]       rid_q;
	logic [31:0]       rsrc_q;
	logic [31:0]       seq_q;

	// channel phases, cleared by reset
	phase_t            phase_q [CHANNELS];

	// channel memories and their read data
	chan_cfg_t         cfg_mem [CHANNELS];
	chan_dyn_t         dyn_mem [CHANNELS];
	chan_cfg_t         cfg_s1;
	chan_dyn_t         dyn_s1;

	// holding stage and output register
	evt_item_t         pend_q;
	logic              pend_valid_q;
	evt_item_t         evt_q;
	logic              evt_valid_q;

	// control
	logic              accept;
	logic              walk_start;
	logic              out_free;
	logic              walk_go;
	logic              walk_end;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              sel_ok;
	logic [IDX_W-1:0]  sel_idx;

	// evaluation results
	phase_t            cur_ph;
	phase_t            new_ph;
	logic              emit;
	logic              cred_dec;
	logic              seq_adv;
	chan_dyn_t         dyn_wd;
	evt_item_t         res;
	logic [31:0]       seq_inc;
	logic [7:0]        att_base;
	logic [CNT_W-1:0]  count_nx;
	logic              evt_load;

	assign accept     = cmd_valid && !cmd_stall;
	assign cmd_stall  = (state_q != ST_IDLE);
	assign walk_start = accept && (cmd.func == FN_TICK || cmd.func == FN_REPLY);
	assign out_free   = !evt_valid_q || !evt_stall;
	assign sel_ok     = (32'(cmd.channel_sel) < 32'(CHANNELS));
	assign sel_idx    = IDX_W'(cmd.channel_sel);
	assign seq_inc    = seq_q + SEQ_STEP;
	assign cur_ph     = phase_q[idx_q];

	// channel evaluation
	always_comb begin
		emit     = 1'b0;
		new_ph   = cur_ph;
		cred_dec = 1'b0;
		seq_adv  = 1'b0;
		dyn_wd   = dyn_s1;
		att_base = (cur_ph == PH_ARMED) ? 8'd0 : dyn_s1.attempts;
		res.channel_num = 3'(idx_q);
		res.event_kind  = EV_DONE;
		res.seq_id      = 32'd0;
		res.dest_ip     = cfg_s1.addr;
		res.success     = 1'b0;
		res.last        = 1'b0;
		if (func_q == FN_TICK) begin
			priority if (cur_ph == PH_ARMED && !cfg_s1.addr_ok) begin
				dyn_wd.attempts = 8'd0;
				new_ph          = PH_DONE;
				emit            = 1'b1;
			end else if (cur_ph == PH_ARMED || cur_ph == PH_RETRY) begin
				dyn_wd.attempts = att_base;
				if (cred_q != 4'd0) begin
					cred_dec         = 1'b1;
					seq_adv          = 1'b1;
					dyn_wd.expect_id = seq_inc;
					dyn_wd.attempts  = (att_base == ATTEMPTS_MAX) ? ATTEMPTS_MAX
						: att_base + 8'd1;
					dyn_wd.deadline  = now_q + cfg_s1.timeout;
					new_ph           = PH_WAIT;
					emit             = 1'b1;
					res.event_kind   = EV_SEND;
					res.seq_id       = seq_inc;
				end
			end else if (cur_ph == PH_WAIT && now_q > dyn_s1.deadline) begin
				if (dyn_s1.attempts < cfg_s1.limit) begin
					new_ph = PH_RETRY;
				end else begin
					new_ph = PH_DONE;
					emit   = 1'b1;
				end
			end else begin
				new_ph = cur_ph;
			end
		end else begin
			if (cur_ph == PH_WAIT && dyn_s1.expect_id == rid_q && cfg_s1.addr == rsrc_q) begin
				new_ph      = PH_DONE;
				emit        = 1'b1;
				res.success = 1'b1;
			end
		end
	end

	// walk progress
	always_comb begin
		walk_go  = (state_q == ST_WALK) && !(emit && pend_valid_q && !out_free);
		count_nx = count_q + CNT_W'(emit);
		walk_end = (idx_q == IDX_W'(CHANNELS - 1)) || (count_nx == CNT_W'(MAX_RESULTS));
		rd_en    = walk_start || (walk_go && !walk_end);
		rd_addr  = (state_q == ST_IDLE) ? '0 : IDX_W'(idx_q + 1'b1);
		evt_load = (walk_go && emit && pend_valid_q)
			|| (state_q == ST_FLUSH && pend_valid_q && out_free);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (walk_start) state_d = ST_WALK;
			ST_WALK:  if (walk_go && walk_end) state_d = ST_FLUSH;
			ST_FLUSH: if (!pend_valid_q || out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			count_q <= '0;
			seq_q   <= SEQ_RESET;
			cred_q  <= 4'd0;
		end else begin
			state_q <= state_d;
			if (walk_start) begin
				idx_q   <= '0;
				count_q <= '0;
				cred_q  <= cmd.tx_credits;
			end else if (walk_go) begin
				count_q <= count_nx;
				if (!walk_end) idx_q <= IDX_W'(idx_q + 1'b1);
				if (cred_dec) cred_q <= cred_q - 4'd1;
				if (seq_adv) seq_q <= seq_inc;
			end
		end
	end

	// latched item fields
	always_ff @(posedge clk) begin
		if (walk_start) begin
			func_q <= cmd.func;
			now_q  <= cmd.now;
			rid_q  <= cmd.reply_id;
			rsrc_q <= cmd.reply_src_ip;
		end
	end

	// channel phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) phase_q[i] <= PH_IDLE;
		end else begin
			if (accept && sel_ok && cmd.func == FN_START) phase_q[sel_idx] <= PH_ARMED;
			else if (accept && sel_ok && cmd.func == FN_STOP) phase_q[sel_idx] <= PH_IDLE;
			else if (walk_go) phase_q[idx_q] <= new_ph;
		end
	end

	// settings memory
	always_ff @(posedge clk) begin
		if (accept && sel_ok && cmd.func == FN_START) begin
			cfg_mem[sel_idx] <= '{addr: cmd.target_ip, addr_ok: cmd.ip_valid,
				timeout: cmd.timeout_ticks, limit: cmd.max_retries};
		end
		if (rd_en) cfg_s1 <= cfg_mem[rd_addr];
	end

	// progress memory
	always_ff @(posedge clk) begin
		if (walk_go) dyn_mem[idx_q] <= dyn_wd;
		if (rd_en) dyn_s1 <= dyn_mem[rd_addr];
	end

	// holding stage and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			evt_valid_q  <= 1'b0;
		end else begin
			if (walk_go && emit) pend_valid_q <= 1'b1;
			else if (state_q == ST_FLUSH && out_free) pend_valid_q <= 1'b0;
			if (evt_load) evt_valid_q <= 1'b1;
			else if (!evt_stall) evt_valid_q <= 1'b0;
		end
	end

	// holding stage and output register data
	always_ff @(posedge clk) begin
		if (walk_go && emit) pend_q <= res;
		if (evt_load) begin
			evt_q <= '{channel_num: pend_q.channel_num, event_kind: pend_q.event_kind,
				seq_id: pend_q.seq_id, dest_ip: pend_q.dest_ip,
				success: pend_q.success, last: (state_q == ST_FLUSH)};
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

`ifndef NO_ASSERTIONS
	// result count never passes the cap
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RESULTS))
		else $error("result count above cap");

	// a send request is only made with credit left
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_go && seq_adv) |-> (cred_q != 4'd0))
		else $error("send without credit");

	// the output register is only loaded from a held result
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		evt_load |-> pend_valid_q)
		else $error("output loaded from empty holding stage");

	// a finished walk leaves nothing held
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && state_d == ST_IDLE) |=> !pend_valid_q)
		else $error("result left behind after walk");

	// a result marked last is only shown after the walk has ended
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_load && state_q == ST_FLUSH) |=> (state_q == ST_IDLE))
		else $error("last result before walk end");
`endif

endmodule

// File: tb/multichannel_ping_retry_engine_tb.sv
// self-checking testbench for the multichannel ping retry engine
module multichannel_ping_retry_engine_tb
	import mpre_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS = CHANNELS_DEF;

	// receiver stall modes
	localparam int STALL_NONE  = 0;
	localparam int STALL_HALF  = 1;
	localparam int STALL_HEAVY = 2;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd       = '0;
	logic      evt_valid;
	logic      evt_stall = 1'b0;
	evt_item_t evt;

	// predicted channel table
	phase_t      tbl_phase [CHANNELS] = '{default: PH_IDLE};
	logic [31:0] tbl_addr [CHANNELS];
	logic        tbl_addr_ok [CHANNELS];
	logic [31:0] tbl_timeout [CHANNELS];
	logic [7:0]  tbl_limit [CHANNELS];
	logic [7:0]  tbl_tries [CHANNELS] = '{default: 8'd0};
	logic [31:0] tbl_deadline [CHANNELS];
	logic [31:0] tbl_echo_id [CHANNELS];
	logic [31:0] seq_word = SEQ_RESET;

	// results still owed by the block, oldest first
	evt_item_t pending_evts[$];

	int mismatches = 0;
	int burst_left = 0;
	logic [31:0] clock_now = '0;
	int n_tick = 0, n_start = 0, n_stop = 0, n_reply = 0;
	int n_checked = 0, n_requests = 0, n_answered = 0, n_failed = 0;
	int stall_mode = STALL_NONE;
	int stall_left = 0;

	multichannel_ping_retry_engine #(
		.CHANNELS(CHANNELS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one line per mismatch, printing capped to keep the log short
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 100) begin
			$display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
		end
	endtask

	function automatic evt_item_t pack_evt(input int ch, input ev_kind_t kind,
			input logic [31:0] seq, input logic [31:0] dest, input logic ok);
		evt_item_t ev;
		ev.channel_num = ch[2:0];
		ev.event_kind  = kind;
		ev.seq_id      = seq;
		ev.dest_ip     = dest;
		ev.success     = ok;
		ev.last        = 1'b0;
		return ev;
	endfunction

	// update the channel table for one accepted item and queue its results
	task automatic advance_channels(input cmd_item_t it);
		evt_item_t batch[$];
		logic [3:0] credits;
		int ch;
		ch = int'(it.channel_sel);
		credits = it.tx_credits;
		case (it.func)
			FN_START: begin
				if (ch < CHANNELS) begin
					tbl_addr[ch]    = it.target_ip;
					tbl_addr_ok[ch] = it.ip_valid;
					tbl_timeout[ch] = it.timeout_ticks;
					tbl_limit[ch]   = it.max_retries;
					tbl_phase[ch]   = PH_ARMED;
				end
			end
			FN_STOP: begin
				if (ch < CHANNELS) tbl_phase[ch] = PH_IDLE;
			end
			FN_TICK: begin
				for (int c = 0; c < CHANNELS && batch.size() < MAX_RESULTS; c++) begin
					if (tbl_phase[c] == PH_ARMED && !tbl_addr_ok[c]) begin
						// unusable address fails at once
						tbl_tries[c] = '0;
						tbl_phase[c] = PH_DONE;
						batch.push_back(pack_evt(c, EV_DONE, '0, tbl_addr[c], 1'b0));
					end else if (tbl_phase[c] == PH_ARMED || tbl_phase[c] == PH_RETRY) begin
						if (tbl_phase[c] == PH_ARMED) tbl_tries[c] = '0;
						if (credits != 0) begin
							credits--;
							seq_word += SEQ_STEP;
							tbl_echo_id[c] = seq_word;
							if (tbl_tries[c] != ATTEMPTS_MAX) tbl_tries[c]++;
							tbl_deadline[c] = it.now + tbl_timeout[c];
							tbl_phase[c] = PH_WAIT;
							batch.push_back(pack_evt(c, EV_SEND, seq_word, tbl_addr[c], 1'b0));
						end
					end else if (tbl_phase[c] == PH_WAIT && it.now > tbl_deadline[c]) begin
						// expired: retry while attempts remain
						if (tbl_tries[c] < tbl_limit[c]) begin
							tbl_phase[c] = PH_RETRY;
						end else begin
							tbl_phase[c] = PH_DONE;
							batch.push_back(pack_evt(c, EV_DONE, '0, tbl_addr[c], 1'b0));
						end
					end
				end
			end
			default: begin
				// reply completes every matching waiting channel
				for (int c = 0; c < CHANNELS && batch.size() < MAX_RESULTS; c++) begin
					if (tbl_phase[c] == PH_WAIT && tbl_echo_id[c] == it.reply_id &&
							tbl_addr[c] == it.reply_src_ip) begin
						tbl_phase[c] = PH_DONE;
						batch.push_back(pack_evt(c, EV_DONE, '0, tbl_addr[c], 1'b1));
					end
				end
			end
		endcase
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) pending_evts.push_back(batch[i]);
	endtask

	// drive one item, wait for it to be taken, then maybe leave a gap
	task automatic send_cmd(input cmd_item_t it);
		cmd_valid <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (cmd_stall);
		advance_channels(it);
		case (it.func)
			FN_TICK:  n_tick++;
			FN_START: n_start++;
			FN_STOP:  n_stop++;
			default:  n_reply++;
		endcase
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
				$urandom_range(0, 8);
		end
	endtask

	// every field random, so unused fields toggle too
	function automatic cmd_item_t random_fill();
		cmd_item_t it;
		it.func          = func_t'($urandom_range(0, 3));
		it.channel_sel   = 3'($urandom_range(0, 7));
		it.target_ip     = $urandom;
		it.ip_valid      = 1'($urandom_range(0, 1));
		it.timeout_ticks = $urandom;
		it.max_retries   = 8'($urandom_range(0, 255));
		it.reply_id      = $urandom;
		it.reply_src_ip  = $urandom;
		it.now           = $urandom;
		it.tx_credits    = 4'($urandom_range(0, 15));
		return it;
	endfunction

	task automatic send_start(input int ch, input logic [31:0] ip, input logic ok,
			input logic [31:0] tmo, input logic [7:0] lim);
		cmd_item_t it;
		it = random_fill();
		it.func          = FN_START;
		it.channel_sel   = ch[2:0];
		it.target_ip     = ip;
		it.ip_valid      = ok;
		it.timeout_ticks = tmo;
		it.max_retries   = lim;
		send_cmd(it);
	endtask

	task automatic send_stop(input int ch);
		cmd_item_t it;
		it = random_fill();
		it.func        = FN_STOP;
		it.channel_sel = ch[2:0];
		send_cmd(it);
	endtask

	task automatic send_tick(input logic [31:0] now, input logic [3:0] credits);
		cmd_item_t it;
		it = random_fill();
		it.func       = FN_TICK;
		it.now        = now;
		it.tx_credits = credits;
		send_cmd(it);
	endtask

	task automatic send_reply(input logic [31:0] id, input logic [31:0] src);
		cmd_item_t it;
		it = random_fill();
		it.func         = FN_REPLY;
		it.reply_id     = id;
		it.reply_src_ip = src;
		send_cmd(it);
	endtask

	// request goes out, near misses are ignored, the true answer completes
	task automatic test_echo_answered();
		send_start(0, 32'hFFFF_FFFF, 1'b1, 32'd10, 8'd3);
		send_tick(32'd0, 4'd1);
		send_reply(tbl_echo_id[0], 32'h0000_0000);
		send_reply(tbl_echo_id[0] ^ 32'h8000_0000, tbl_addr[0]);
		send_reply(tbl_echo_id[0], tbl_addr[0]);
	endtask

	// unusable address fails on the first tick even without credit
	task automatic test_bad_address();
		send_start(1, 32'h0000_0000, 1'b0, 32'd4, 8'd2);
		send_tick(32'd1, 4'd0);
	endtask

	// channels wait for credit, largest timeout wraps the deadline
	task automatic test_credit_shortage();
		send_start(2, 32'hC0A8_0102, 1'b1, 32'd2, 8'd0);
		send_start(3, 32'h0A00_0003, 1'b1, 32'hFFFF_FFFF, 8'd255);
		send_tick(32'd2, 4'd0);
		send_tick(32'd3, 4'd1);
		send_tick(32'd4, 4'd15);
	endtask

	// zero retry limit: one request, then failure after the deadline passes
	task automatic test_zero_retry();
		send_start(4, 32'h5555_AAAA, 1'b1, 32'd5, 8'd0);
		send_tick(32'd10, 4'd8);
		send_tick(32'd15, 4'd8);
		send_tick(32'd16, 4'd0);
	endtask

	// wrapped deadline expires on the next tick, then the channel fails
	task automatic test_deadline_wrap();
		send_start(5, 32'hAAAA_5555, 1'b1, 32'hFFFF_FFF0, 8'd1);
		send_tick(32'h0000_0020, 4'd1);
		send_tick(32'h0000_0021, 4'd1);
		send_tick(32'h0000_0022, 4'd1);
		send_reply(tbl_echo_id[5], tbl_addr[5]);
	endtask

	// stopped channel ignores its answer, zero timeout waits across a wrap
	task automatic test_stop_and_idle();
		send_stop(3);
		send_reply(tbl_echo_id[3], tbl_addr[3]);
		send_stop(6);
		send_start(7, $urandom, 1'b1, 32'd0, 8'd255);
		send_tick(32'hFFFF_FFFF, 4'd15);
		send_tick(32'd0, 4'd15);
		send_tick(32'd1, 4'd15);
	endtask

	// mostly well-formed traffic with random content, some noise
	task automatic test_random_traffic(input int count);
		int waiting[$];
		int pick;
		int ch;
		logic [31:0] tmo;
		logic [7:0] lim;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				clock_now += $urandom_range(0, 6);
				if ($urandom_range(0, 19) == 0) clock_now = $urandom;
				send_tick(clock_now, ($urandom_range(0, 3) == 0) ?
					4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3)));
			end else if (pick < 62) begin
				case ($urandom_range(0, 19))
					0, 1, 2:  tmo = $urandom;
					3:        tmo = 32'd0;
					4:        tmo = 32'hFFFF_FFFF;
					default:  tmo = $urandom_range(0, 12);
				endcase
				lim = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(0, 3));
				send_start($urandom_range(0, CHANNELS - 1), $urandom,
					$urandom_range(0, 9) != 0, tmo, lim);
			end else if (pick < 92) begin
				waiting.delete();
				for (int c = 0; c < CHANNELS; c++) begin
					if (tbl_phase[c] == PH_WAIT) waiting.push_back(c);
				end
				pick = $urandom_range(0, 9);
				if (waiting.size() > 0 && pick < 9) begin
					ch = waiting[$urandom_range(0, waiting.size() - 1)];
					if (pick < 7) send_reply(tbl_echo_id[ch], tbl_addr[ch]);
					else send_reply(tbl_echo_id[ch], $urandom);
				end else begin
					send_reply($urandom, $urandom);
				end
			end else begin
				send_stop($urandom_range(0, CHANNELS - 1));
			end
		end
	endtask

	// sender holds off until every owed result has come back
	task automatic test_drain_pause();
		cmd_valid <= 1'b0;
		while (pending_evts.size() != 0) @(posedge clk);
		repeat (CHANNELS + 4) @(posedge clk);
	endtask

	// receiver stall pattern, switching mode at random
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(STALL_NONE, STALL_HEAVY);
			stall_left <= $urandom_range(10, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE: evt_stall <= 1'b0;
			STALL_HALF: evt_stall <= ($urandom_range(0, 1) == 1);
			default:    evt_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// compare each taken result with the oldest prediction
	always @(posedge clk) begin : check_evt
		evt_item_t want;
		if (arst_n && evt_valid && !evt_stall) begin
			if (pending_evts.size() == 0) begin
				report_mismatch("result with none expected", evt[69:38], evt.seq_id);
			end else begin
				want = pending_evts.pop_front();
				n_checked++;
				if (want.event_kind == EV_SEND) n_requests++;
				else if (want.success) n_answered++;
				else n_failed++;
				if (evt.channel_num !== want.channel_num)
					report_mismatch("channel_num", 32'(evt.channel_num),
						32'(want.channel_num));
				if (evt.event_kind !== want.event_kind)
					report_mismatch("event_kind", 32'(evt.event_kind),
						32'(want.event_kind));
				if (evt.seq_id !== want.seq_id)
					report_mismatch("seq_id", evt.seq_id, want.seq_id);
				if (evt.dest_ip !== want.dest_ip)
					report_mismatch("dest_ip", evt.dest_ip, want.dest_ip);
				if (evt.success !== want.success)
					report_mismatch("success", 32'(evt.success), 32'(want.success));
				if (evt.last !== want.last)
					report_mismatch("last", 32'(evt.last), 32'(want.last));
			end
		end
	end

	// test sequence
	initial begin : run_tests
		int settle;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_echo_answered();
		test_bad_address();
		test_credit_shortage();
		test_zero_retry();
		test_deadline_wrap();
		test_stop_and_idle();
		clock_now = $urandom;
		test_random_traffic(116);
		test_drain_pause();
		test_random_traffic(116);
		cmd_valid <= 1'b0;
		settle = 0;
		while (pending_evts.size() != 0 && settle < 50000) begin
			@(posedge clk);
			settle++;
		end
		repeat (3 * CHANNELS) @(posedge clk);
		if (pending_evts.size() != 0)
			report_mismatch("results never arrived", pending_evts.size(), 0);
		$display("run covered %0d items: %0d ticks, %0d starts, %0d stops, %0d replies",
			n_tick + n_start + n_stop + n_reply, n_tick, n_start, n_stop, n_reply);
		$display("checked %0d results: %0d echo requests, %0d answered, %0d failed",
			n_checked, n_requests, n_answered, n_failed);
		if (mismatches == 0) begin
			$display("multichannel_ping_retry_engine_tb: clean");
		end else begin
			$display("multichannel_ping_retry_engine_tb: errors");
		end
		$finish;
	end

	// hang guard
	initial begin
		#5ms;
		$display("multichannel_ping_retry_engine_tb: errors");
		$finish;
	end

endmodule

// File: sim.f
src/mpre_pkg.sv
src/multichannel_ping_retry_engine.sv
tb/multichannel_ping_retry_engine_tb.sv
